// ===== rtl/float_to_pcm16_with_fnv_hash_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FLOAT_TO_PCM16_WITH_FNV_HASH_UNIT_MACROS_SVH
`define FLOAT_TO_PCM16_WITH_FNV_HASH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define F2P_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define F2P_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/f2p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package f2p_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'd435;  // prime is 2**40 + 435
  localparam logic [14:0] PCM_SCALE    = 15'd32767;
  localparam logic [23:0] COUNT_MAX    = 24'hffffff;
  localparam logic [7:0]  EXP_ALL      = 8'hff;
  localparam logic [15:0] PCM_POS_MAX  = 16'h7fff;
  localparam logic [15:0] PCM_NEG_MAX  = 16'h8000;

  // Classified request carried from front to back
  typedef struct packed {
    logic [31:0] bits;
    logic        start;
    logic        nf;
    logic        tiny;
  } item_t;

  // One FNV-1a byte step; the prime multiply is a shift plus a product by a 9-bit constant
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/float_to_pcm16_with_fnv_hash_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts float32 audio samples to saturating 16-bit PCM (scale by 32767, round
// half to even) and keeps a running FNV-1a 64 hash, peak magnitude and clip and
// non-finite counts, all cleared by a request with start_of_utterance set. Each
// request passes through the back end in steps: the scale multiply, the single
// precision rounding, the integer rounding and the final stats update, with one
// FNV byte step in each of them. A new request is taken from the queue only as
// the previous one finishes its final step, which waits while the output is stalled.
// A two-entry queue lets the input side run ahead while the output is stalled.
module float_to_pcm16_with_fnv_hash_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [31:0]   in_sample_bits,
  input  wire logic          in_start_of_utterance,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [15:0] out_pcm_value,
  output logic               out_clipped,
  output logic               out_not_finite,
  output logic [63:0]        out_running_hash,
  output logic [30:0]        out_peak_magnitude_bits,
  output logic [23:0]        out_clip_total,
  output logic [23:0]        out_nonfinite_total
);

  f2p_pkg::item_t push_item, head;
  logic push, pop, empty, full;

  f2p_front u_front (
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample_bits        (in_sample_bits),
    .in_start_of_utterance (in_start_of_utterance),
    .q_full                (full),
    .q_push                (push),
    .q_item                (push_item)
  );

  f2p_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  f2p_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_head                  (head),
    .q_empty                 (empty),
    .q_pop                   (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_pcm_value           (out_pcm_value),
    .out_clipped             (out_clipped),
    .out_not_finite          (out_not_finite),
    .out_running_hash        (out_running_hash),
    .out_peak_magnitude_bits (out_peak_magnitude_bits),
    .out_clip_total          (out_clip_total),
    .out_nonfinite_total     (out_nonfinite_total)
  );

endmodule
`default_nettype wire

// ===== rtl/f2p_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module f2p_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       in_sample_bits,
  input  wire logic              in_start_of_utterance,
  input  wire logic              q_full,
  output logic                   q_push,
  output f2p_pkg::item_t         q_item
);

  // Accept while the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // Classify the sample by its exponent field
  always_comb begin
    q_item.bits  = in_sample_bits;
    q_item.start = in_start_of_utterance;
    q_item.nf    = (in_sample_bits[30:23] == f2p_pkg::EXP_ALL);
    q_item.tiny  = (in_sample_bits[30:23] == 8'd0);
  end

endmodule
`default_nettype wire

// ===== rtl/f2p_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module f2p_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire f2p_pkg::item_t push_item,
  input  wire logic           pop,
  output f2p_pkg::item_t      head,
  output logic                empty,
  output logic                full
);

  f2p_pkg::item_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot_r[rd_ptr_r];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/f2p_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module f2p_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire f2p_pkg::item_t q_head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic signed [15:0]  out_pcm_value,
  output logic                out_clipped,
  output logic                out_not_finite,
  output logic [63:0]         out_running_hash,
  output logic [30:0]         out_peak_magnitude_bits,
  output logic [23:0]         out_clip_total,
  output logic [23:0]         out_nonfinite_total
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_NORM, ST_RND, ST_FIN} state_t;

  state_t             state_r;
  f2p_pkg::item_t     cur_r;
  logic [38:0]        prod_r;
  logic [24:0]        sig_r;
  logic signed [9:0]  k_r;
  logic signed [15:0] pcm_r;
  logic               clip_r;
  logic [63:0]        hw_r, hash_r;
  logic [30:0]        peak_r;
  logic [23:0]        clip_cnt_r, nf_cnt_r;

  logic               out_valid_r;
  logic signed [15:0] out_pcm_r;
  logic               out_clip_r, out_nf_r;
  logic [63:0]        out_hash_r;
  logic [30:0]        out_peak_r;
  logic [23:0]        out_clip_cnt_r, out_nf_cnt_r;

  logic [38:0]        prod_nxt;
  logic [24:0]        sig_nxt;
  logic signed [9:0]  k_nxt;
  logic signed [15:0] pcm_nxt;
  logic               clip_nxt;
  logic [63:0]        hw_nxt;
  logic [30:0]        peak_nxt;
  logic [23:0]        clip_cnt_nxt, nf_cnt_nxt;
  logic               done, take;

  logic               lead, guard, sticky;
  logic [23:0]        sig24;
  logic [9:0]         sh;
  logic [4:0]         sh5;
  logic [24:0]        trunc, rem, half, mask, mag;
  logic               frac_nz, rnd_up, big;
  logic [30:0]        peak_base;
  logic [23:0]        clip_base, nf_base;

  assign done  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign take  = !q_empty && ((state_r == ST_IDLE) || done);
  assign q_pop = take;

  // Multiply the significand by the scale
  always_comb begin
    prod_nxt = 39'({1'b1, cur_r.bits[22:0]}) * 39'(f2p_pkg::PCM_SCALE);
  end

  // Round the product to single precision
  always_comb begin
    lead = prod_r[38];
    if (lead) begin
      sig24  = prod_r[38:15];
      guard  = prod_r[14];
      sticky = |prod_r[13:0];
    end else begin
      sig24  = prod_r[37:14];
      guard  = prod_r[13];
      sticky = |prod_r[12:0];
    end
    sig_nxt = {1'b0, sig24} + {24'd0, guard & (sticky | sig24[0])};
    k_nxt   = $signed({2'b00, cur_r.bits[30:23]}) - 10'sd136 + $signed({9'd0, lead});
  end

  // Round to integer, ties to even, and saturate; non-finite and tiny samples give zero
  always_comb begin
    big     = !k_r[9];
    sh      = 10'(-k_r);
    sh5     = sh[4:0];
    trunc   = 25'd0;
    rem     = 25'd0;
    mask    = 25'd0;
    half    = 25'd0;
    frac_nz = 1'b1;
    rnd_up  = 1'b0;
    if (!big && sh < 10'd26) begin
      trunc   = sig_r >> sh5;
      mask    = (25'd1 << sh5) - 25'd1;
      rem     = sig_r & mask;
      half    = 25'd1 << (sh5 - 5'd1);
      frac_nz = (rem != 25'd0);
      rnd_up  = (rem > half) || ((rem == half) && trunc[0]);
    end
    mag = trunc + {24'd0, rnd_up};
    if (cur_r.nf || cur_r.tiny) begin
      clip_nxt = 1'b0;
      pcm_nxt  = 16'sd0;
    end else if (!cur_r.bits[31]) begin
      clip_nxt = big || (trunc > 25'd32767) || ((trunc == 25'd32767) && frac_nz);
      pcm_nxt  = clip_nxt ? f2p_pkg::PCM_POS_MAX : mag[15:0];
    end else begin
      clip_nxt = big || (trunc > 25'd32768) || ((trunc == 25'd32768) && frac_nz);
      pcm_nxt  = clip_nxt ? f2p_pkg::PCM_NEG_MAX : 16'(16'd0 - mag[15:0]);
    end
  end

  // Hash byte for the current step
  always_comb begin
    case (state_r)
      ST_MUL:  hw_nxt = f2p_pkg::fnv_step(cur_r.start ? f2p_pkg::FNV_BASIS : hash_r,
                                          cur_r.bits[7:0]);
      ST_NORM: hw_nxt = f2p_pkg::fnv_step(hw_r, cur_r.bits[15:8]);
      ST_RND:  hw_nxt = f2p_pkg::fnv_step(hw_r, cur_r.bits[23:16]);
      ST_FIN:  hw_nxt = f2p_pkg::fnv_step(hw_r, cur_r.bits[31:24]);
      default: hw_nxt = hw_r;
    endcase
  end

  // Update peak and counts
  always_comb begin
    peak_base = cur_r.start ? 31'd0 : peak_r;
    clip_base = cur_r.start ? 24'd0 : clip_cnt_r;
    nf_base   = cur_r.start ? 24'd0 : nf_cnt_r;
    peak_nxt  = (!cur_r.nf && cur_r.bits[30:0] > peak_base) ? cur_r.bits[30:0] : peak_base;
    clip_cnt_nxt = (clip_r && clip_base != f2p_pkg::COUNT_MAX) ? clip_base + 24'd1 : clip_base;
    nf_cnt_nxt   = (cur_r.nf && nf_base != f2p_pkg::COUNT_MAX) ? nf_base + 24'd1 : nf_base;
  end

  // Sequence the steps and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hash_r      <= f2p_pkg::FNV_BASIS;
      peak_r      <= 31'd0;
      clip_cnt_r  <= 24'd0;
      nf_cnt_r    <= 24'd0;
    end else begin
      if (out_valid_r && !out_stall && !done) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            cur_r   <= q_head;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          hw_r    <= hw_nxt;
          state_r <= ST_NORM;
        end
        ST_NORM: begin
          sig_r   <= sig_nxt;
          k_r     <= k_nxt;
          hw_r    <= hw_nxt;
          state_r <= ST_RND;
        end
        ST_RND: begin
          pcm_r   <= pcm_nxt;
          clip_r  <= clip_nxt;
          hw_r    <= hw_nxt;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (done) begin
            hash_r         <= hw_nxt;
            peak_r         <= peak_nxt;
            clip_cnt_r     <= clip_cnt_nxt;
            nf_cnt_r       <= nf_cnt_nxt;
            out_valid_r    <= 1'b1;
            out_pcm_r      <= pcm_r;
            out_clip_r     <= clip_r;
            out_nf_r       <= cur_r.nf;
            out_hash_r     <= hw_nxt;
            out_peak_r     <= peak_nxt;
            out_clip_cnt_r <= clip_cnt_nxt;
            out_nf_cnt_r   <= nf_cnt_nxt;
            if (take) begin
              cur_r   <= q_head;
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_pcm_value           = out_pcm_r;
  assign out_clipped             = out_clip_r;
  assign out_not_finite          = out_nf_r;
  assign out_running_hash        = out_hash_r;
  assign out_peak_magnitude_bits = out_peak_r;
  assign out_clip_total          = out_clip_cnt_r;
  assign out_nonfinite_total     = out_nf_cnt_r;

endmodule
`default_nettype wire

// ===== rtl/f2p_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "float_to_pcm16_with_fnv_hash_unit_macros.svh"
module f2p_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_pcm_value,
  input wire logic               out_clipped,
  input wire logic               out_not_finite,
  input wire logic [63:0]        out_running_hash
);

  // Hold a stalled result
  `F2P_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `F2P_ASSERT_NEXT(a_hold_hash, out_valid && out_stall, $stable(out_running_hash))
  // Non-finite samples give zero and never clip
  `F2P_ASSERT_IMPL(a_nf_zero, out_valid && out_not_finite, out_pcm_value == 16'sd0 && !out_clipped)
  // Clipped results sit at a rail
  `F2P_ASSERT_IMPL(a_clip_rail, out_valid && out_clipped, out_pcm_value == 16'sh7fff || out_pcm_value == 16'sh8000)

endmodule

bind float_to_pcm16_with_fnv_hash_unit f2p_checker u_f2p_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pcm_value    (out_pcm_value),
  .out_clipped      (out_clipped),
  .out_not_finite   (out_not_finite),
  .out_running_hash (out_running_hash)
);
`default_nettype wire
